// ===== design/cst_pkg.sv =====
// Package for the counting semaphore table: table sizes, operation and
// status codes, and the request and result records shared by the bank and top level.
// No dependencies.
package cst_pkg;

	localparam int NUM_SEMAPHORES = 16;
	localparam int COUNT_BITS     = 16;
	localparam int IDX_BITS       = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;

	localparam logic [31:0] COUNT_MAX = 32'((64'd1 << COUNT_BITS) - 64'd1);

	localparam logic [1:0] OP_OPEN   = 2'd0;
	localparam logic [1:0] OP_WAIT   = 2'd1;
	localparam logic [1:0] OP_SIGNAL = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BLOCK   = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [IDX_BITS-1:0]   idx_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [7:0]  sem_handle;
		logic [15:0] initial_count;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  handle_out;
		logic [15:0] count_after;
		logic        wake;
	} rsp_t;

endpackage

// ===== design/cst_if.sv =====
// Valid/ready channel interfaces for the counting semaphore table:
// one for requests, one for results. No dependencies.
interface cst_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [7:0]  sem_handle;
	logic [15:0] initial_count;

	modport source (output valid, output operation, output sem_handle,
		output initial_count, input ready);
	modport sink (input valid, input operation, input sem_handle,
		input initial_count, output ready);
endinterface

interface cst_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [3:0]  handle_out;
	logic [15:0] count_after;
	logic        wake;

	modport source (output valid, output status, output handle_out,
		output count_after, output wake, input ready);
	modport sink (input valid, input status, input handle_out,
		input count_after, input wake, output ready);
endinterface

// ===== design/cst_bank.sv =====
// Semaphore bank: in-use marks and counts, with the
// read-modify-write for one request. Depends on cst_pkg.
module cst_bank (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  cst_pkg::req_t req,
	output cst_pkg::rsp_t rsp
);
	import cst_pkg::*;

	logic [NUM_SEMAPHORES-1:0] in_use_q;
	count_t                    count_q [NUM_SEMAPHORES];

	logic   free_found;
	idx_t   free_idx;
	idx_t   idx;
	logic   handle_ok;
	count_t cur;
	count_t init_sat;
	logic   wr_en;
	logic   set_use;
	idx_t   wr_idx;
	count_t wr_val;

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NUM_SEMAPHORES - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_BITS'(i);
			end
		end
	end

	assign idx       = IDX_BITS'(req.sem_handle);
	assign handle_ok = ({1'b0, req.sem_handle} < 9'(NUM_SEMAPHORES)) && in_use_q[idx];
	assign cur       = count_q[idx];
	assign init_sat  = (32'(req.initial_count) > COUNT_MAX) ? COUNT_BITS'(COUNT_MAX)
		: COUNT_BITS'(req.initial_count);

	always_comb begin
		rsp.status      = ST_INVALID;
		rsp.handle_out  = 4'(req.sem_handle);
		rsp.count_after = '0;
		rsp.wake        = 1'b0;
		wr_en           = 1'b0;
		set_use         = 1'b0;
		wr_idx          = idx;
		wr_val          = cur;
		case (req.operation)
			OP_OPEN: begin
				if (free_found) begin
					rsp.status      = ST_OK;
					rsp.handle_out  = 4'(free_idx);
					rsp.count_after = 16'(init_sat);
					wr_en           = 1'b1;
					set_use         = 1'b1;
					wr_idx          = free_idx;
					wr_val          = init_sat;
				end else begin
					rsp.status     = ST_FULL;
					rsp.handle_out = '0;
				end
			end
			OP_WAIT: begin
				if (handle_ok) begin
					if (cur == '0) begin
						rsp.status = ST_BLOCK;
					end else begin
						rsp.status      = ST_OK;
						wr_val          = cur - COUNT_BITS'(1);
						rsp.count_after = 16'(wr_val);
						wr_en           = 1'b1;
					end
				end
			end
			OP_SIGNAL: begin
				if (handle_ok) begin
					rsp.status      = ST_OK;
					rsp.wake        = 1'b1;
					wr_val          = (32'(cur) < COUNT_MAX) ? cur + COUNT_BITS'(1) : cur;
					rsp.count_after = 16'(wr_val);
					wr_en           = 1'b1;
				end
			end
			default: begin
				rsp.status = ST_INVALID;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
		end else if (step && set_use) begin
			in_use_q[wr_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (step && wr_en) begin
			count_q[wr_idx] <= wr_val;
		end
	end

endmodule

// ===== design/counting_semaphore_table.sv =====
// Top level of the counting semaphore table: request register, semaphore
// bank and result register. Depends on cst_pkg, cst_if and cst_bank.
//
// Usage:
//   req carries one request (operation, sem_handle, initial_count); it is
//   taken at a clock edge where req.valid and req.ready are both high.
//   rsp returns exactly one result per request (status, handle_out,
//   count_after, wake), in request order, taken where rsp.valid and
//   rsp.ready are both high.
//   Path: an accepted request waits in the request register, goes through
//   the bank, and its result is captured in the result register.
//   Throughput: one request per cycle unless rsp stalls; the bank's
//   read-modify-write and free-entry priority encode finish before the next
//   request reaches the bank, so each request sees the effect of the one before it.
//   Stall: while rsp is held, the result register keeps its result and the
//   request register keeps one more request; req.ready drops once both are
//   full and returns as soon as rsp.ready does.
//   Reset (arst_n low): every entry is marked free, both registers empty.
//   Counts are loaded by open, so they need no reset.
module counting_semaphore_table (
	input logic clk,
	input logic arst_n,
	cst_req_if.sink   req,
	cst_rsp_if.source rsp
);
	import cst_pkg::*;

	logic valid_s1;
	req_t req_s1;
	logic rsp_valid_q;
	rsp_t rsp_q;
	rsp_t bank_rsp;
	logic advance;

	assign advance   = !rsp_valid_q || rsp.ready;
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (advance) begin
				rsp_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_s1.operation     <= req.operation;
			req_s1.sem_handle    <= req.sem_handle;
			req_s1.initial_count <= req.initial_count;
		end
		if (advance && valid_s1) begin
			rsp_q <= bank_rsp;
		end
	end

	cst_bank u_bank (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance && valid_s1),
		.req    (req_s1),
		.rsp    (bank_rsp)
	);

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_q.status;
	assign rsp.handle_out  = rsp_q.handle_out;
	assign rsp.count_after = rsp_q.count_after;
	assign rsp.wake        = rsp_q.wake;

endmodule
